// ===== design/natural_to_hierarchical_index_core_assert.svh =====
// Assertion macros shared by the grid index pipeline.
`ifndef NATURAL_TO_HIERARCHICAL_INDEX_CORE_ASSERT_SVH
`define NATURAL_TO_HIERARCHICAL_INDEX_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on aclk, off during reset.
`define NTHI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nthi assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define NTHI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nthi assertion failed");

`else

`define NTHI_ASSERT_IMP(lbl, ante, cons)
`define NTHI_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/nthi_pkg.sv =====
// Constants and types for the natural-to-hierarchical grid index pipeline.
package nthi_pkg;

    localparam int MAX_SIDE   = 1024;
    localparam int MAX_LEVELS = 16;

    localparam int COORD_W = 10;
    localparam int SIDE_W  = 11;
    localparam int LVL_W   = 5;
    localparam int IDX_W   = 30;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    localparam int PROD_W = 20;
    localparam int ACC_W  = 21;
    localparam int WH_W   = 21;
    localparam int LIN_W  = 20;
    localparam int AZ_W   = 31;

    // One stage per split, then stages for the leaf offset and the final sum.
    localparam int LVL_STAGES = MAX_LEVELS - 1;
    localparam int K_LIN      = LVL_STAGES + 1;
    localparam int K_CZ       = LVL_STAGES + 2;
    localparam int K_AZ       = LVL_STAGES + 3;
    localparam int NUM_STAGES = LVL_STAGES + 4;
    localparam int K_OUT      = NUM_STAGES;

    typedef enum logic [1:0] {
        REG_NUM_LEVELS = 2'd0,
        REG_X_SIZE     = 2'd1,
        REG_Y_SIZE     = 2'd2,
        REG_Z_SIZE     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                oor;
        logic [COORD_W-1:0]  rx;
        logic [COORD_W-1:0]  ry;
        logic [COORD_W-1:0]  cz;
        logic [SIDE_W-1:0]   w;
        logic [SIDE_W-1:0]   h;
        logic [SIDE_W-1:0]   m1a;
        logic [COORD_W-1:0]  m1b;
        logic [COORD_W-1:0]  m2a;
        logic [SIDE_W-1:0]   m2b;
        logic [PROD_W-1:0]   p1;
        logic [PROD_W-1:0]   p2;
        logic [ACC_W-1:0]    acc;
        logic [WH_W-1:0]     wh;
        logic [LIN_W-1:0]    lin;
        logic [IDX_W-1:0]    czwh;
        logic [AZ_W-1:0]     az;
        logic [IDX_W-1:0]    idx;
    } stg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             oor;
    } res_t;

endpackage

// ===== design/natural_to_hierarchical_index_core.sv =====
// Natural grid coordinate to hierarchical (recursive quadrant) index pipeline.
//
// Input beats (s_coord_x/y/z) arrive on a valid/ready channel; each produces
// exactly one result beat (m_hier_index, m_out_of_range) in order.
// Grid extents and the number of hierarchy levels are set over the APB port
// (num_levels at 0x0, x_size 0x4, y_size 0x8, z_size 0xC); the user must write
// them only while no beat is in flight, as the block does not enforce this.
// Sizes above 1024 count as 1024, zero levels as one level, more than 16 as 16.
// Throughput: one beat per cycle while the skid register is empty. Each
// quadrant split has its own stage (15 split stages), followed by stages for
// the leaf offset multiplies and the final add; the two quadrant-area
// multiplies trail the split decision by one stage and the accumulate by two.
// A coordinate not below its size gives m_out_of_range = 1 and index 0.
// Reset clears all valid bits and loads the registers with their defaults.
// When the receiver stalls, the result waits in the output register and a
// second skid register catches the next one; input is still taken until a
// beat lands in the skid register, and only then does the whole pipeline hold.
`include "natural_to_hierarchical_index_core_assert.svh"

module natural_to_hierarchical_index_core
    import nthi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    // coordinate input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [COORD_W-1:0]   s_coord_x,
    input  logic [COORD_W-1:0]   s_coord_y,
    input  logic [COORD_W-1:0]   s_coord_z,
    // index output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_hier_index,
    output logic                 m_out_of_range
);

    // configuration registers
    logic [LVL_W-1:0]  levels_reg, levels_next;
    logic [SIDE_W-1:0] x_size_reg, x_size_next;
    logic [SIDE_W-1:0] y_size_reg, y_size_next;
    logic [SIDE_W-1:0] z_size_reg, z_size_next;
    reg_idx_t          reg_sel;
    logic              cfg_wr;

    logic [SIDE_W-1:0] xs_eff, ys_eff, zs_eff;
    logic [LVL_W-1:0]  lv_eff;

    // pipeline
    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    stg_t                  pipe_reg  [NUM_STAGES];
    stg_t                  pipe_next [NUM_STAGES];
    stg_t                  fin;
    logic                  adv;

    // output register and skid
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic out_vld_reg, out_vld_next;
    logic skid_vld_reg, skid_vld_next;

    // One stage of work: a quadrant split when the level is active, the
    // area multiplies of the previous split, the accumulate of the one
    // before, and the leaf and final terms at the tail stages.
    function automatic stg_t stage_step(input stg_t p, input int k,
                                        input logic [LVL_W-1:0] lv,
                                        input logic [SIDE_W-1:0] zs);
        stg_t                      q;
        logic [COORD_W-1:0]        lw;
        logic [COORD_W-1:0]        bh;
        logic [SIDE_W-1:0]         rw;
        logic [SIDE_W-1:0]         th;
        logic                      right;
        logic                      top;
        logic [SIDE_W+COORD_W-1:0] prod1;
        logic [SIDE_W+COORD_W-1:0] prod2;
        logic [2*SIDE_W-1:0]       wh_full;
        logic [2*SIDE_W-1:0]       lin_full;
        logic [IDX_W:0]            cz_full;
        logic [DATA_W-1:0]         az_full;
        logic [AZ_W-1:0]           sum;
        q     = p;
        lw    = p.w[SIDE_W-1:1];
        bh    = p.h[SIDE_W-1:1];
        rw    = p.w - {1'b0, lw};
        th    = p.h - {1'b0, bh};
        right = p.rx >= lw;
        top   = p.ry >= bh;

        prod1 = (SIDE_W+COORD_W)'(p.m1a) * (SIDE_W+COORD_W)'(p.m1b);
        prod2 = (SIDE_W+COORD_W)'(p.m2a) * (SIDE_W+COORD_W)'(p.m2b);
        q.p1  = prod1[PROD_W-1:0];
        q.p2  = prod2[PROD_W-1:0];
        q.acc = p.acc + ACC_W'(p.p1) + ACC_W'(p.p2);

        q.m1a = '0;
        q.m1b = '0;
        q.m2a = '0;
        q.m2b = '0;
        if ((k <= LVL_STAGES) && (LVL_W'(k) < lv)) begin
            // quadrant offset = (top ? w*bh : 0) + (right ? lw*h_new : 0)
            q.m1a = top ? p.w : '0;
            q.m1b = bh;
            q.m2a = right ? lw : '0;
            q.m2b = top ? th : {1'b0, bh};
            q.w   = right ? rw : {1'b0, lw};
            q.h   = top ? th : {1'b0, bh};
            q.rx  = right ? (p.rx - lw) : p.rx;
            q.ry  = top ? (p.ry - bh) : p.ry;
        end

        if (k == K_LIN) begin
            wh_full  = (2*SIDE_W)'(p.w) * (2*SIDE_W)'(p.h);
            lin_full = (2*SIDE_W)'(p.ry) * (2*SIDE_W)'(p.w) + (2*SIDE_W)'(p.rx);
            q.wh     = wh_full[WH_W-1:0];
            q.lin    = lin_full[LIN_W-1:0];
        end
        if (k == K_CZ) begin
            cz_full = (IDX_W+1)'(p.cz) * (IDX_W+1)'(p.wh);
            q.czwh  = cz_full[IDX_W-1:0];
        end
        if (k == K_AZ) begin
            az_full = DATA_W'(p.acc) * DATA_W'(zs);
            q.az    = az_full[AZ_W-1:0];
            q.czwh  = p.czwh + IDX_W'(p.lin);
        end
        if (k == K_OUT) begin
            sum   = p.az + AZ_W'(p.czwh);
            q.idx = p.oor ? '0 : sum[IDX_W-1:0];
        end
        return q;
    endfunction

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb begin
        levels_next = levels_reg;
        x_size_next = x_size_reg;
        y_size_next = y_size_reg;
        z_size_next = z_size_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_NUM_LEVELS: levels_next = pwdata[LVL_W-1:0];
                REG_X_SIZE:     x_size_next = pwdata[SIDE_W-1:0];
                REG_Y_SIZE:     y_size_next = pwdata[SIDE_W-1:0];
                REG_Z_SIZE:     z_size_next = pwdata[SIDE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NUM_LEVELS: prdata = DATA_W'(levels_reg);
            REG_X_SIZE:     prdata = DATA_W'(x_size_reg);
            REG_Y_SIZE:     prdata = DATA_W'(y_size_reg);
            REG_Z_SIZE:     prdata = DATA_W'(z_size_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LVL_W'(1);
            x_size_reg <= SIDE_W'(1);
            y_size_reg <= SIDE_W'(1);
            z_size_reg <= SIDE_W'(1);
        end else begin
            levels_reg <= levels_next;
            x_size_reg <= x_size_next;
            y_size_reg <= y_size_next;
            z_size_reg <= z_size_next;
        end
    end

    // clamp extents and level count
    assign xs_eff = (x_size_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : x_size_reg;
    assign ys_eff = (y_size_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : y_size_reg;
    assign zs_eff = (z_size_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : z_size_reg;

    always_comb begin
        lv_eff = levels_reg;
        if (levels_reg == '0) begin
            lv_eff = LVL_W'(1);
        end else if (levels_reg > LVL_W'(MAX_LEVELS)) begin
            lv_eff = LVL_W'(MAX_LEVELS);
        end
    end

    // ---------------- pipeline ----------------
    // Hold every stage while the skid register is occupied.
    assign adv     = !skid_vld_reg;
    assign s_ready = adv;

    always_comb begin
        pipe_next[0]     = '0;
        pipe_next[0].oor = ({1'b0, s_coord_x} >= xs_eff) ||
                           ({1'b0, s_coord_y} >= ys_eff) ||
                           ({1'b0, s_coord_z} >= zs_eff);
        pipe_next[0].rx  = s_coord_x;
        pipe_next[0].ry  = s_coord_y;
        pipe_next[0].cz  = s_coord_z;
        pipe_next[0].w   = xs_eff;
        pipe_next[0].h   = ys_eff;
        for (int k = 1; k < NUM_STAGES; k++) begin
            pipe_next[k] = stage_step(pipe_reg[k-1], k, lv_eff, zs_eff);
        end
    end

    assign fin = stage_step(pipe_reg[NUM_STAGES-1], K_OUT, lv_eff, zs_eff);

    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[NUM_STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // ---------------- output register and skid ----------------
    always_comb begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_next      = out_reg;
        skid_next     = skid_reg;
        if (skid_vld_reg) begin
            // drain the skid beat once the current one leaves
            if (m_ready) begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
        end else if (vld_reg[NUM_STAGES-1]) begin
            if (!out_vld_reg || m_ready) begin
                out_next.idx = fin.idx;
                out_next.oor = fin.oor;
                out_vld_next = 1'b1;
            end else begin
                skid_next.idx = fin.idx;
                skid_next.oor = fin.oor;
                skid_vld_next = 1'b1;
            end
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_vld_reg;
    assign m_hier_index   = out_reg.idx;
    assign m_out_of_range = out_reg.oor;

    // ---------------- assertions ----------------
    `NTHI_ASSERT_NXT(a_accept_enters, s_valid && s_ready, vld_reg[0])
    `NTHI_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, out_vld_reg)
    `NTHI_ASSERT_IMP(a_oor_zero, m_valid && m_out_of_range, m_hier_index == '0)
    `NTHI_ASSERT_IMP(a_leaf_holds_point,
                     vld_reg[LVL_STAGES] && !pipe_reg[LVL_STAGES].oor,
                     (pipe_reg[LVL_STAGES].rx < pipe_reg[LVL_STAGES].w) &&
                     (pipe_reg[LVL_STAGES].ry < pipe_reg[LVL_STAGES].h))
    `NTHI_ASSERT_IMP(a_index_in_grid,
                     m_valid && !m_out_of_range,
                     34'(m_hier_index) < (34'(xs_eff) * 34'(ys_eff) * 34'(zs_eff)))

endmodule
